### sv/mls_pkg.sv
`timescale 1ns / 1ps

package mls_pkg;

  localparam int unsigned TickW       = 10;
  localparam int unsigned LetterW     = 5;
  localparam int unsigned NumLetters  = 26;
  localparam int unsigned MaxElemDef  = 6;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [LetterW-1:0] LastLetter = LetterW'(NumLetters - 1);

  // register map (byte addresses, word index = paddr[3:2])
  localparam logic [1:0] RegDotTicks  = 2'd0;
  localparam logic [1:0] RegDashTicks = 2'd1;
  localparam logic [1:0] RegElemGap   = 2'd2;
  localparam logic [1:0] RegLetterGap = 2'd3;

  localparam logic [TickW-1:0] DotTicksRst  = TickW'(200);
  localparam logic [TickW-1:0] DashTicksRst = TickW'(600);
  localparam logic [TickW-1:0] ElemGapRst   = TickW'(200);
  localparam logic [TickW-1:0] LetterGapRst = TickW'(300);

  // command codes
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdStart = 1'b1;

  typedef struct packed {
    logic [TickW-1:0] dot_ticks;
    logic [TickW-1:0] dash_ticks;
    logic [TickW-1:0] element_gap_ticks;
    logic [TickW-1:0] letter_gap_ticks;
  } cfg_t;

  // element count per letter, A to Z
  localparam logic [2:0] CodeLen [NumLetters] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // element pattern per letter: bit i set means element i is a dash
  localparam logic [7:0] CodePat [NumLetters] = '{
    8'd2, 8'd1, 8'd5, 8'd1, 8'd0, 8'd4, 8'd3, 8'd0, 8'd0, 8'd14, 8'd5, 8'd2, 8'd3,
    8'd1, 8'd7, 8'd6, 8'd11, 8'd2, 8'd0, 8'd1, 8'd4, 8'd8, 8'd6, 8'd9, 8'd13, 8'd3
  };

  // clamp out-of-range letters to A
  function automatic logic [LetterW-1:0] clamp_letter(logic [LetterW-1:0] l);
    return (l > LastLetter) ? '0 : l;
  endfunction

  function automatic logic [3:0] code_len(logic [LetterW-1:0] l);
    return {1'b0, CodeLen[clamp_letter(l)]};
  endfunction

  function automatic logic is_dash(logic [LetterW-1:0] l, logic [2:0] idx);
    logic [7:0] pat;
    pat = CodePat[clamp_letter(l)];
    return pat[idx];
  endfunction

endpackage

### sv/mls_if.sv
`timescale 1ns / 1ps

interface mls_in_if
  import mls_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [LetterW-1:0] letter;

  modport source (output valid, cmd, letter, input ready);
  modport sink   (input valid, cmd, letter, output ready);
endinterface

interface mls_out_if;
  logic valid;
  logic ready;
  logic tone_on;
  logic busy_res;
  logic done_res;

  modport source (output valid, tone_on, busy_res, done_res, input ready);
  modport sink   (input valid, tone_on, busy_res, done_res, output ready);
endinterface

### sv/morse_letter_sender.sv
`timescale 1ns / 1ps

// Morse letter sender. A start item (cmd=1) latches a letter 0=A..25=Z and begins
// sending it; starts while busy or with a letter above 25 are ignored. Each tick item
// (cmd=0) is one unit of time and returns the tone, busy and done flags for that tick:
// tone for dot_ticks or dash_ticks per element, element_gap_ticks of silence after
// each element, letter_gap_ticks more after the last, then one tick with done set.
// Every item gets exactly one result item. The block takes one item per clock while
// the result register is free or being drained: the state update is a single pass
// from the accepted item to a result register, and that register frees in the same
// cycle its item is taken. Timing registers sit on an APB port (dot, dash, element
// gap, letter gap at byte offsets 0, 4, 8, 12) and are meant to be written while no
// letter is in progress.
module morse_letter_sender
  import mls_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MaxElemDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  mls_in_if.sink              in_i,
  mls_out_if.source           out_o
);

  cfg_t cfg;

  mls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mls_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

### sv/mls_cfg.sv
`timescale 1ns / 1ps

module mls_cfg
  import mls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_ticks         <= DotTicksRst;
      cfg_q.dash_ticks        <= DashTicksRst;
      cfg_q.element_gap_ticks <= ElemGapRst;
      cfg_q.letter_gap_ticks  <= LetterGapRst;
    end else if (wr_en) begin
      case (reg_idx)
        RegDotTicks:  cfg_q.dot_ticks         <= pwdata[TickW-1:0];
        RegDashTicks: cfg_q.dash_ticks        <= pwdata[TickW-1:0];
        RegElemGap:   cfg_q.element_gap_ticks <= pwdata[TickW-1:0];
        RegLetterGap: cfg_q.letter_gap_ticks  <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      RegDotTicks:  prdata = ApbDataW'(cfg_q.dot_ticks);
      RegDashTicks: prdata = ApbDataW'(cfg_q.dash_ticks);
      RegElemGap:   prdata = ApbDataW'(cfg_q.element_gap_ticks);
      RegLetterGap: prdata = ApbDataW'(cfg_q.letter_gap_ticks);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/mls_core.sv
`timescale 1ns / 1ps

module mls_core
  import mls_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MaxElemDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  mls_in_if.sink    in_i,
  mls_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(MAX_ELEMENTS);

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTone = 2'd1;
  localparam logic [1:0] PhGap  = 2'd2;
  localparam logic [1:0] PhLgap = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [LetterW-1:0] letter_q, letter_d;
  logic [TickW-1:0]   count_q, count_d;

  logic out_valid_q;
  logic tone_q, busy_q, done_q;
  logic tone_d, busy_d, done_d;

  logic               accept;
  logic [IdxW:0]      next_idx;
  logic [TickW-1:0]   start_len;
  logic [TickW-1:0]   next_len;

  // take a new item whenever the result register is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign next_idx  = {1'b0, idx_q} + 1'b1;
  assign start_len = is_dash(in_i.letter, 3'd0) ? cfg_i.dash_ticks : cfg_i.dot_ticks;
  assign next_len  = is_dash(letter_q, 3'(next_idx[IdxW-1:0])) ?
                     cfg_i.dash_ticks : cfg_i.dot_ticks;

  // next state and result for one item
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    letter_d = letter_q;
    count_d  = count_q;
    tone_d   = 1'b0;
    busy_d   = 1'b0;
    done_d   = 1'b0;
    if (in_i.cmd == CmdStart) begin
      if (phase_q == PhIdle && in_i.letter <= LastLetter) begin
        letter_d = in_i.letter;
        idx_d    = '0;
        phase_d  = PhTone;
        count_d  = start_len;
      end
      tone_d = (phase_d == PhTone);
      busy_d = (phase_d != PhIdle);
    end else begin
      case (phase_q)
        PhTone: begin
          tone_d = 1'b1;
          busy_d = 1'b1;
          if (count_q > TickW'(1)) begin
            count_d = count_q - 1'b1;
          end else begin
            phase_d = PhGap;
            count_d = cfg_i.element_gap_ticks;
          end
        end
        PhGap: begin
          busy_d = 1'b1;
          if (count_q > TickW'(1)) begin
            count_d = count_q - 1'b1;
          end else if (4'(next_idx) >= code_len(letter_q) ||
                       next_idx >= (IdxW+1)'(MAX_ELEMENTS)) begin
            phase_d = PhLgap;
            count_d = cfg_i.letter_gap_ticks;
          end else begin
            idx_d   = next_idx[IdxW-1:0];
            phase_d = PhTone;
            count_d = next_len;
          end
        end
        PhLgap: begin
          if (count_q == '0) begin
            done_d  = 1'b1;
            phase_d = PhIdle;
            idx_d   = '0;
          end else begin
            busy_d  = 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      idx_q    <= '0;
      letter_q <= '0;
      count_q  <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      letter_q <= letter_d;
      count_q  <= count_d;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tone_q <= tone_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.tone_on  = tone_q;
  assign out_o.busy_res = busy_q;
  assign out_o.done_res = done_q;

  // idle always parks the element index at zero
  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> idx_q == '0)
    else $error("element index not cleared while idle");

  // a valid start from idle enters the tone phase
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.cmd == CmdStart && phase_q == PhIdle && in_i.letter <= LastLetter
    |=> phase_q == PhTone && out_o.tone_on && out_o.busy_res)
    else $error("accepted start did not begin a tone");

  // done comes with the tone and busy flags cleared, and returns to idle
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> !tone_q && !busy_q && phase_q == PhIdle)
    else $error("done result inconsistent with state");

  // tone implies busy
  a_tone_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && tone_q |-> busy_q)
    else $error("tone without busy");

endmodule

### dv/morse_letter_sender_tb.sv
`timescale 1ns / 1ps

module morse_letter_sender_tb;
  import mls_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int LongHold   = 300;
  localparam int MaxReports = 30;
  localparam int FlushChunk = 32;

  typedef enum logic [1:0] {PhIdle, PhTone, PhGap, PhLetterGap} key_phase_e;
  typedef enum logic [1:0] {GapsMostlyRecv, GapsMostlySend, GapsOff} gap_mode_e;

  typedef struct packed {
    logic                cmd;
    logic [LetterW-1:0]  letter;
  } key_item_t;

  typedef struct packed {
    logic tone;
    logic busy;
    logic done;
  } key_flags_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  mls_in_if  in_if ();
  mls_out_if out_if ();

  morse_letter_sender dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  // keyer shadow state and timing
  cfg_t                keyer_cfg;
  key_phase_e          k_phase;
  logic [2:0]          k_elem;
  logic [LetterW-1:0]  k_letter;
  logic [TickW-1:0]    k_count;

  key_item_t  pending_items[$];
  key_flags_t expected_flags[$];
  key_flags_t want_flags;
  key_item_t  next_item;

  gap_mode_e idle_mode;
  bit        in_took;
  bit        hold_req;
  int        hold_left;
  int        items_queued;
  int        items_taken;
  int        errors;
  int        cycles;
  int        letters_started;
  int        letters_done;
  int        starts_ignored;
  int        ticks_seen;
  int        timings_used;

  // tone-on length of the current element
  function automatic logic [TickW-1:0] symbol_ticks();
    logic [LetterW-1:0] li;
    li = (k_letter > LastLetter) ? '0 : k_letter;
    return CodePat[li][k_elem] ? keyer_cfg.dash_ticks : keyer_cfg.dot_ticks;
  endfunction

  // advance the shadow keyer by one item and return the flags it reports
  function automatic key_flags_t keyer_step(input logic cmd, input logic [LetterW-1:0] letter);
    key_flags_t         f;
    logic [LetterW-1:0] li;
    int                 nxt;
    f = '0;
    if (cmd == CmdStart) begin
      if (k_phase == PhIdle && letter <= LastLetter) begin
        k_letter = letter;
        k_elem   = '0;
        k_phase  = PhTone;
        k_count  = symbol_ticks();
        letters_started++;
      end else begin
        starts_ignored++;
      end
      f.tone = (k_phase == PhTone);
      f.busy = (k_phase != PhIdle);
    end else begin
      ticks_seen++;
      case (k_phase)
        PhTone: begin
          f.tone = 1'b1;
          f.busy = 1'b1;
          if (k_count > 1) begin
            k_count = k_count - 1'b1;
          end else begin
            k_phase = PhGap;
            k_count = keyer_cfg.element_gap_ticks;
          end
        end
        PhGap: begin
          f.busy = 1'b1;
          if (k_count > 1) begin
            k_count = k_count - 1'b1;
          end else begin
            li  = (k_letter > LastLetter) ? '0 : k_letter;
            nxt = int'(k_elem) + 1;
            if (nxt >= int'(CodeLen[li]) || nxt >= int'(MaxElemDef)) begin
              k_phase = PhLetterGap;
              k_count = keyer_cfg.letter_gap_ticks;
            end else begin
              k_elem  = 3'(nxt);
              k_phase = PhTone;
              k_count = symbol_ticks();
            end
          end
        end
        PhLetterGap: begin
          if (k_count == 0) begin
            f.done  = 1'b1;
            k_phase = PhIdle;
            k_elem  = '0;
            letters_done++;
          end else begin
            f.busy  = 1'b1;
            k_count = k_count - 1'b1;
          end
        end
        default: ;
      endcase
    end
    return f;
  endfunction

  function automatic int send_gap_pct();
    case (idle_mode)
      GapsMostlyRecv: return 34;
      GapsMostlySend: return 47;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_gap_pct();
    case (idle_mode)
      GapsMostlyRecv: return 47;
      GapsMostlySend: return 34;
      default:        return 0;
    endcase
  endfunction

  function automatic void queue_item(input logic cmd, input logic [LetterW-1:0] letter);
    key_item_t item;
    item.cmd    = cmd;
    item.letter = letter;
    pending_items.push_back(item);
    items_queued++;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               expected_flags.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sample both handshakes: predict on input items, check output items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        expected_flags.push_back(keyer_step(in_if.cmd, in_if.letter));
        items_taken++;
        in_took = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_flags.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: result item with nothing expected: tone=%0b busy=%0b done=%0b",
                     $time, out_if.tone_on, out_if.busy_res, out_if.done_res);
        end else begin
          want_flags = expected_flags.pop_front();
          if (out_if.tone_on !== want_flags.tone || out_if.busy_res !== want_flags.busy ||
              out_if.done_res !== want_flags.done) begin
            errors++;
            if (errors <= MaxReports)
              $display("%0t: mismatch, expected tone=%0b busy=%0b done=%0b, got %0b %0b %0b",
                       $time, want_flags.tone, want_flags.busy, want_flags.done,
                       out_if.tone_on, out_if.busy_res, out_if.done_res);
          end
        end
      end
    end
  end

  // driver: offer the next pending item, with random gaps
  always @(negedge clk_i) begin
    if (!in_if.valid || in_took) begin
      in_took = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
        next_item = pending_items.pop_front();
        in_if.valid  <= 1'b1;
        in_if.cmd    <= next_item.cmd;
        in_if.letter <= next_item.letter;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LongHold;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_gap_pct());
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [TickW-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = ApbDataW'(val);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // read back all timing registers against the shadow copy
  task automatic check_regs();
    logic [ApbDataW-1:0] rd;
    logic [TickW-1:0]    vals[4];
    vals[RegDotTicks]  = keyer_cfg.dot_ticks;
    vals[RegDashTicks] = keyer_cfg.dash_ticks;
    vals[RegElemGap]   = keyer_cfg.element_gap_ticks;
    vals[RegLetterGap] = keyer_cfg.letter_gap_ticks;
    for (int r = RegDotTicks; r <= RegLetterGap; r++) begin
      apb_read(2'(r), rd);
      if (rd !== ApbDataW'(vals[r])) begin
        errors++;
        $display("%0t: register %0d readback, expected %0d, got %0d", $time, r, vals[r], rd);
      end
    end
    @(posedge clk_i);
  endtask

  task automatic set_timing(input int dot, input int dash, input int egap, input int lgap);
    keyer_cfg.dot_ticks         = TickW'(dot);
    keyer_cfg.dash_ticks        = TickW'(dash);
    keyer_cfg.element_gap_ticks = TickW'(egap);
    keyer_cfg.letter_gap_ticks  = TickW'(lgap);
    apb_write(RegDotTicks, keyer_cfg.dot_ticks);
    apb_write(RegDashTicks, keyer_cfg.dash_ticks);
    apb_write(RegElemGap, keyer_cfg.element_gap_ticks);
    apb_write(RegLetterGap, keyer_cfg.letter_gap_ticks);
    check_regs();
    timings_used++;
  endtask

  // hold until every queued item is taken and every result has come back
  task automatic wait_drain();
    do @(negedge clk_i); while (items_taken != items_queued || expected_flags.size() != 0);
    @(posedge clk_i);
  endtask

  // tick until the letter in flight has finished
  task automatic run_to_idle();
    wait_drain();
    while (k_phase != PhIdle) begin
      repeat (FlushChunk) queue_item(CmdTick, LetterW'($urandom));
      wait_drain();
    end
  endtask

  // mostly whole letters with random content, some bad starts and loose ticks
  task automatic send_random(input int target);
    int made;
    int span;
    int longest;
    int n;
    int r;
    made = 0;
    while (made < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        longest = (keyer_cfg.dot_ticks > keyer_cfg.dash_ticks) ?
                  keyer_cfg.dot_ticks : keyer_cfg.dash_ticks;
        span = 4 * (longest + keyer_cfg.element_gap_ticks + 2) +
               keyer_cfg.letter_gap_ticks + 2;
        queue_item(CmdStart, LetterW'($urandom_range(NumLetters - 1)));
        n = $urandom_range(span, span / 2);
        made += n + 1;
        repeat (n) begin
          if ($urandom_range(19) == 0)
            queue_item(CmdStart, LetterW'($urandom));
          queue_item(CmdTick, LetterW'($urandom));
        end
      end else if (r < 85) begin
        queue_item(CmdStart, LetterW'($urandom_range(31, NumLetters)));
        n = $urandom_range(4);
        made += n;
        repeat (n) queue_item(CmdTick, LetterW'($urandom));
      end else begin
        n = $urandom_range(8, 1);
        made += n;
        repeat (n) begin
          if ($urandom_range(3) == 0)
            queue_item(CmdStart, LetterW'($urandom));
          queue_item(CmdTick, LetterW'($urandom));
        end
      end
    end
  endtask

  // stimulus
  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.cmd    = CmdTick;
    in_if.letter = '0;
    out_if.ready = 1'b0;
    idle_mode    = GapsMostlyRecv;
    keyer_cfg.dot_ticks         = DotTicksRst;
    keyer_cfg.dash_ticks        = DashTicksRst;
    keyer_cfg.element_gap_ticks = ElemGapRst;
    keyer_cfg.letter_gap_ticks  = LetterGapRst;
    k_phase  = PhIdle;
    k_elem   = '0;
    k_letter = '0;
    k_count  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset timing: E on the reset dot length, gaps shortened mid-letter
    check_regs();
    queue_item(CmdTick, '0);
    queue_item(CmdStart, 5'd4);
    queue_item(CmdStart, 5'd31);
    queue_item(CmdTick, 5'd31);
    queue_item(CmdTick, '1);
    wait_drain();
    set_timing(1, 1, 1, 0);
    run_to_idle();

    // shortest timing with no letter gap: A, then P cut off by a mid-letter change
    set_timing(1, 1, 1, 0);
    queue_item(CmdStart, LetterW'(NumLetters));
    queue_item(CmdStart, 5'd31);
    queue_item(CmdTick, '0);
    queue_item(CmdStart, 5'd0);
    queue_item(CmdStart, LastLetter);
    repeat (6) queue_item(CmdTick, '0);
    queue_item(CmdStart, 5'd15);
    repeat (3) queue_item(CmdTick, '0);
    wait_drain();

    // zero lengths, written while P is still in progress
    set_timing(0, 0, 0, 0);
    repeat (10) queue_item(CmdTick, '0);
    queue_item(CmdStart, 5'd16);
    run_to_idle();

    // longest timing: J opens with a full-length dot, the rest shortened mid-letter
    set_timing(1023, 1023, 1023, 1023);
    queue_item(CmdStart, 5'd9);
    queue_item(CmdTick, '0);
    wait_drain();
    set_timing(1, 1, 1, 0);
    run_to_idle();

    // random phases; two of them with a long result hold-off
    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = (ph < 4) ? GapsMostlyRecv : (ph < 8) ? GapsMostlySend : GapsOff;
      if (ph == 6)
        set_timing($urandom_range(40, 8), $urandom_range(40, 8), $urandom_range(20, 4),
                   $urandom_range(40));
      else
        set_timing($urandom_range(5), $urandom_range(6), $urandom_range(4),
                   $urandom_range(5));
      if (ph == 2 || ph == 9)
        hold_req = 1'b1;
      send_random(25);
      wait_drain();
    end

    repeat (8) @(posedge clk_i);
    errors += expected_flags.size();
    $display("Covered %0d letters started and %0d finished over %0d ticks, %0d starts ignored",
             letters_started, letters_done, ticks_seen, starts_ignored);
    $display("Timing settings applied: %0d, from all zero to all maximum", timings_used);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
